FILE: rtl/snake_order_index_generator_core_macros.svh
// Assertion macros used by the checker module.
// Property arguments must not contain a top-level comma.
`ifndef SNAKE_ORDER_INDEX_GENERATOR_CORE_MACROS_SVH
`define SNAKE_ORDER_INDEX_GENERATOR_CORE_MACROS_SVH

// Checked on every clock edge outside reset.
`define SNOIG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every clock edge, reset included.
`define SNOIG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

FILE: rtl/snoic_pkg.sv
`default_nettype none

package snoic_pkg;

    localparam int NUM_DIMS   = 4;
    localparam int COORD_W    = 4;
    localparam int SIZE_W     = 5;
    localparam int FLAT_W     = 16;
    localparam int MAX_EXTENT = 16;
    localparam int IDX_W      = 2;
    localparam int IN_W       = 8;
    localparam int OUT_W      = FLAT_W + NUM_DIMS * COORD_W;

    localparam logic [IDX_W-1:0] REG_SIZE_DIM0 = 2'd0;
    localparam logic [IDX_W-1:0] REG_SIZE_DIM1 = 2'd1;
    localparam logic [IDX_W-1:0] REG_SIZE_DIM2 = 2'd2;
    localparam logic [IDX_W-1:0] REG_SIZE_DIM3 = 2'd3;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [SIZE_W-1:0]  size_t;
    typedef logic [FLAT_W-1:0]  flat_t;
    typedef coord_t [NUM_DIMS-1:0] coord_vec_t;

    // One position on its way through the flat index pipeline.
    typedef struct packed {
        coord_vec_t coords;
        logic       last;
    } item_t;

    // Update command broadcast to every coordinate cell.
    typedef struct packed {
        logic step;
        logic clear;
    } cell_ctrl_t;

    // A size of zero acts as one, and sizes above the maximum extent are clamped.
    function automatic size_t eff_size(input size_t s);
        size_t r;
        if (s == '0)
        begin
            r = SIZE_W'(1);
        end
        else if (s > SIZE_W'(MAX_EXTENT))
        begin
            r = SIZE_W'(MAX_EXTENT);
        end
        else
        begin
            r = s;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/snoic_cell.sv
`default_nettype none

module snoic_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  snoic_pkg::cell_ctrl_t ctrl,
    input  snoic_pkg::size_t    size,
    input  logic                odd_in,
    input  logic                inner_moves,
    output logic                odd_out,
    output logic                moves_out,
    output snoic_pkg::coord_t   coord
);

    snoic_pkg::coord_t pos_reg;
    snoic_pkg::coord_t pos_next;
    logic              can_move;
    logic              mine;

    // An odd count of odd coordinates above this cell reverses its direction.
    always_comb
    begin
        if (odd_in)
        begin
            can_move = (pos_reg != '0);
        end
        else
        begin
            can_move = (({1'b0, pos_reg} + snoic_pkg::SIZE_W'(1)) < size);
        end
    end

    assign mine      = can_move && !inner_moves;
    assign odd_out   = odd_in ^ pos_reg[0];
    assign moves_out = inner_moves || can_move;
    assign coord     = pos_reg;

    always_comb
    begin
        pos_next = pos_reg;
        if (ctrl.step)
        begin
            if (ctrl.clear)
            begin
                pos_next = '0;
            end
            else if (mine)
            begin
                if (odd_in)
                begin
                    pos_next = pos_reg - snoic_pkg::COORD_W'(1);
                end
                else
                begin
                    pos_next = pos_reg + snoic_pkg::COORD_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/snoic_mac_stage.sv
`default_nettype none

module snoic_mac_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  snoic_pkg::flat_t   in_acc,
    input  snoic_pkg::item_t   in_item,
    input  snoic_pkg::coord_t  addend,
    input  snoic_pkg::size_t   size,
    output logic               out_valid,
    input  logic               out_ready,
    output snoic_pkg::flat_t   out_acc,
    output snoic_pkg::item_t   out_item
);

    logic                                          valid_reg;
    snoic_pkg::flat_t                              acc_reg;
    snoic_pkg::flat_t                              acc_next;
    snoic_pkg::item_t                              item_reg;
    logic [snoic_pkg::FLAT_W+snoic_pkg::SIZE_W-1:0] prod;

    // One Horner step of the row-major index; it never exceeds 16 bits.
    assign prod     = in_acc * size;
    assign acc_next = prod[snoic_pkg::FLAT_W-1:0] + snoic_pkg::FLAT_W'(addend);

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_acc   = acc_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            acc_reg  <= acc_next;
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/snake_order_index_generator_core.sv
`default_nettype none

// Snake-order position generator for a grid of up to four dimensions, each of
// extent 1 to 16 (dimension 0 outermost). Every input word yields one output
// word: bit 0 of s_tdata set restarts at the origin, clear advances one step,
// and an advance from the final position wraps to the origin. The block takes
// one word per clock while m_tready stays high. The next position is found
// combinationally and held in a row of coordinate cells, and the row-major
// index then comes out of three registered multiply-add stages. The user must
// write the size registers only while no word is in flight; the block itself
// does not enforce this. A new size applies to the walk from its stored
// coordinates onward.
module snake_order_index_generator_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [snoic_pkg::IDX_W-1:0]   cfg_index,
    input  logic [snoic_pkg::SIZE_W-1:0]  cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [snoic_pkg::IN_W-1:0]    s_tdata,   // [0] restart, [7:1] zero
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [snoic_pkg::OUT_W-1:0]   m_tdata,   // flat_index, coord0..coord3
    output logic                          m_tlast    // is_last
);

    localparam int ND = snoic_pkg::NUM_DIMS;

    snoic_pkg::size_t      size_reg [ND];
    snoic_pkg::size_t      eff      [ND];
    logic                  odd      [ND+1];
    logic                  moves    [ND+1];
    snoic_pkg::coord_vec_t pos;
    snoic_pkg::cell_ctrl_t ctrl;
    logic                  v1_reg;

    logic                  stage_valid [ND];
    logic                  stage_ready [ND];
    snoic_pkg::flat_t      stage_acc   [ND];
    snoic_pkg::item_t      stage_item  [ND];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ND; i++)
            begin
                size_reg[i] <= snoic_pkg::SIZE_W'(1);
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                snoic_pkg::REG_SIZE_DIM0: size_reg[0] <= cfg_data;
                snoic_pkg::REG_SIZE_DIM1: size_reg[1] <= cfg_data;
                snoic_pkg::REG_SIZE_DIM2: size_reg[2] <= cfg_data;
                snoic_pkg::REG_SIZE_DIM3: size_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < ND; i++)
        begin
            eff[i] = snoic_pkg::eff_size(size_reg[i]);
        end
    end

    // Parity runs from the outer cells inward; the move claim runs outward.
    assign odd[0]    = 1'b0;
    assign moves[ND] = 1'b0;

    assign ctrl.step  = s_tvalid && s_tready;
    assign ctrl.clear = s_tdata[0] || !moves[0];

    for (genvar d = 0; d < ND; d++)
    begin : g_cell
        snoic_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .size        (eff[d]),
            .odd_in      (odd[d]),
            .inner_moves (moves[d+1]),
            .odd_out     (odd[d+1]),
            .moves_out   (moves[d]),
            .coord       (pos[d])
        );
    end

    // The cells hold the newest position; v1_reg marks it as not yet indexed.
    assign s_tready = !v1_reg || stage_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            v1_reg <= s_tvalid;
        end
    end

    assign stage_valid[0]     = v1_reg;
    assign stage_acc[0]       = snoic_pkg::FLAT_W'(pos[0]);
    assign stage_item[0]      = '{coords: pos, last: !moves[0]};
    assign stage_ready[ND-1]  = m_tready;

    for (genvar k = 0; k < ND - 1; k++)
    begin : g_mac
        snoic_mac_stage u_mac (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[k]),
            .in_ready  (stage_ready[k]),
            .in_acc    (stage_acc[k]),
            .in_item   (stage_item[k]),
            .addend    (stage_item[k].coords[k+1]),
            .size      (eff[k+1]),
            .out_valid (stage_valid[k+1]),
            .out_ready (stage_ready[k+1]),
            .out_acc   (stage_acc[k+1]),
            .out_item  (stage_item[k+1])
        );
    end

    assign m_tvalid = stage_valid[ND-1];
    assign m_tdata  = {stage_item[ND-1].coords, stage_acc[ND-1]};
    assign m_tlast  = stage_item[ND-1].last;

endmodule

`default_nettype wire

FILE: rtl/snoic_checker.sv
`default_nettype none

`include "snake_order_index_generator_core_macros.svh"

module snoic_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [snoic_pkg::OUT_W-1:0]   m_tdata,
    input  logic                          m_tlast
);

    logic out_stall;

    assign out_stall = m_tvalid && !m_tready;

    // A stalled output word holds still.
    `SNOIG_ASSERT(a_out_hold, out_stall |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)), "output word changed while stalled")

    // With no result waiting the block must be able to take a word.
    `SNOIG_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready, "input not ready while output is empty")

    // The flat index is zero exactly at the origin.
    `SNOIG_ASSERT(a_origin_index, m_tvalid |-> ((m_tdata[15:0] == 16'd0) == (m_tdata[31:16] == 16'd0)), "flat index and coordinates disagree at the origin")

    // The first cycle after reset shows no result.
    `SNOIG_ASSERT_ALWAYS(a_reset_empty, $rose(rst_n) |-> !m_tvalid, "output valid right after reset")

endmodule

bind snake_order_index_generator_core snoic_checker u_checker (.*);

`default_nettype wire

FILE: bench/snake_order_index_generator_core_tb.sv
module snake_order_index_generator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One expected output word: flat index, coordinates (dimension 0 lowest) and end flag.
    typedef struct packed {
        snoic_pkg::flat_t      flat;
        snoic_pkg::coord_vec_t coords;
        logic                  last;
    } grid_word_t;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_THREE_OF_FOUR,
        READY_RARE_STALL
    } stall_mode_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [snoic_pkg::IDX_W-1:0]     cfg_index = '0;
    logic [snoic_pkg::SIZE_W-1:0]    cfg_data = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [snoic_pkg::IN_W-1:0]      s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [snoic_pkg::OUT_W-1:0]     m_tdata;
    logic                            m_tlast;

    // Walk state and size registers as the block should hold them.
    snoic_pkg::size_t  size_regs [snoic_pkg::NUM_DIMS];
    snoic_pkg::coord_t walk_pos  [snoic_pkg::NUM_DIMS];

    logic        pending_restarts [$];
    grid_word_t  expected_positions [$];
    int          mismatches = 0;
    int          words_seen = 0;
    int          words_queued = 0;

    // Sender burst state.
    int          burst_left = 0;
    int          gap_left = 0;
    logic        word_held;

    // Receiver stall state.
    stall_mode_t stall_mode = READY_ALWAYS;
    int          mode_left = 0;
    int          pattern_tick = 0;
    int          hold_left = 0;
    int          hold_mark = 0;
    logic        ready_next;

    snake_order_index_generator_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #1 clk = ~clk;

    function automatic int extent_of(input int d);
        int s;
        s = int'(size_regs[d]);
        if (s == 0)
        begin
            s = 1;
        end
        else if (s > snoic_pkg::MAX_EXTENT)
        begin
            s = snoic_pkg::MAX_EXTENT;
        end
        return s;
    endfunction

    // Innermost dimension that can still move in its direction, or -1 at the end of the walk.
    function automatic int moving_dim(output bit down);
        bit rev;
        down = 1'b0;
        for (int d = snoic_pkg::NUM_DIMS - 1; d >= 0; d--)
        begin
            rev = 1'b0;
            for (int i = 0; i < d; i++)
            begin
                rev ^= walk_pos[i][0];
            end
            if (rev)
            begin
                if (walk_pos[d] != '0)
                begin
                    down = 1'b1;
                    return d;
                end
            end
            else if (int'(walk_pos[d]) + 1 < extent_of(d))
            begin
                return d;
            end
        end
        return -1;
    endfunction

    function automatic grid_word_t step_snake(input logic restart);
        grid_word_t w;
        int         d;
        bit         down;
        int         idx;
        int         stride;
        d = -1;
        down = 1'b0;
        if (!restart)
        begin
            d = moving_dim(down);
        end
        if (d < 0)
        begin
            for (int i = 0; i < snoic_pkg::NUM_DIMS; i++)
            begin
                walk_pos[i] = '0;
            end
        end
        else if (down)
        begin
            walk_pos[d] = walk_pos[d] - 1'b1;
        end
        else
        begin
            walk_pos[d] = walk_pos[d] + 1'b1;
        end
        idx = 0;
        stride = 1;
        for (int i = snoic_pkg::NUM_DIMS - 1; i >= 0; i--)
        begin
            idx = (idx + int'(walk_pos[i]) * stride) & 'hFFFF;
            stride = (stride * extent_of(i)) & 'h1FFFF;
        end
        w.flat = snoic_pkg::flat_t'(idx);
        for (int i = 0; i < snoic_pkg::NUM_DIMS; i++)
        begin
            w.coords[i] = walk_pos[i];
        end
        w.last = (moving_dim(down) < 0);
        return w;
    endfunction

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    // Driver: offers queued words in bursts with random gaps in between.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end
        else
        begin
            word_held = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                expected_positions.insert(expected_positions.size(), step_snake(s_tdata[0]));
                word_held = 1'b0;
            end
            if (!word_held)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_restarts.size() > 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {{(snoic_pkg::IN_W - 1){1'b0}}, pending_restarts.pop_front()};
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 60);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Two long hold-offs let the block fill up and push back on its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_mark <= 0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if ((words_seen == 150 || words_seen == 350) && words_seen != hold_mark)
        begin
            hold_left <= 200;
            hold_mark <= words_seen;
        end
    end

    // Monitor: checks each output word and drives the receiver's stall pattern.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                words_seen++;
                if (expected_positions.size() == 0)
                begin
                    note_failure($sformatf("unexpected word flat %h coords %h last %b",
                                           m_tdata[snoic_pkg::FLAT_W-1:0],
                                           m_tdata[snoic_pkg::OUT_W-1:snoic_pkg::FLAT_W],
                                           m_tlast));
                end
                else
                begin
                    grid_word_t want;
                    want = expected_positions.pop_front();
                    if (m_tdata[snoic_pkg::FLAT_W-1:0] !== want.flat
                        || m_tdata[snoic_pkg::OUT_W-1:snoic_pkg::FLAT_W] !== want.coords
                        || m_tlast !== want.last)
                    begin
                        note_failure($sformatf(
                            {"word %0d: expected flat %h coords %h last %b,",
                             " got flat %h coords %h last %b"},
                            words_seen, want.flat, want.coords, want.last,
                            m_tdata[snoic_pkg::FLAT_W-1:0],
                            m_tdata[snoic_pkg::OUT_W-1:snoic_pkg::FLAT_W], m_tlast));
                    end
                end
            end
            if (hold_left > 0)
            begin
                ready_next = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = stall_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 80);
                end
                mode_left--;
                pattern_tick++;
                case (stall_mode)
                    READY_ALWAYS:        ready_next = 1'b1;
                    READY_COIN:          ready_next = ($urandom_range(0, 1) == 1);
                    READY_THREE_OF_FOUR: ready_next = (pattern_tick % 4) != 3;
                    default:             ready_next = $urandom_range(0, 7) != 0;
                endcase
            end
            m_tready <= ready_next;
        end
    end

    task automatic write_size(input logic [snoic_pkg::IDX_W-1:0] idx,
                              input snoic_pkg::size_t value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        size_regs[idx] = value;
    endtask

    task automatic set_sizes(input snoic_pkg::size_t s0, input snoic_pkg::size_t s1,
                             input snoic_pkg::size_t s2, input snoic_pkg::size_t s3);
        write_size(snoic_pkg::REG_SIZE_DIM0, s0);
        write_size(snoic_pkg::REG_SIZE_DIM1, s1);
        write_size(snoic_pkg::REG_SIZE_DIM2, s2);
        write_size(snoic_pkg::REG_SIZE_DIM3, s3);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic void add_word(input logic restart);
        pending_restarts.insert(pending_restarts.size(), restart);
        words_queued++;
    endfunction

    task automatic queue_words(input int count, input logic restart);
        repeat (count) add_word(restart);
    endtask

    // Sizes are mostly small so walks wrap often; zero and oversize values show up too.
    function automatic snoic_pkg::size_t pick_size();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return '0;
        end
        else if (r == 1)
        begin
            return snoic_pkg::size_t'($urandom_range(17, 31));
        end
        else if (r == 2)
        begin
            return snoic_pkg::size_t'(snoic_pkg::MAX_EXTENT);
        end
        return snoic_pkg::size_t'($urandom_range(1, 4));
    endfunction

    // Every queued word has come back out once the monitor has seen them all.
    task automatic wait_idle();
        while (words_seen < words_queued)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
    endtask

    initial
    begin
        for (int i = 0; i < snoic_pkg::NUM_DIMS; i++)
        begin
            size_regs[i] = snoic_pkg::size_t'(1);
            walk_pos[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Single-cell grid: an advance right after reset wraps to the origin.
        queue_words(1, 1'b0);
        queue_words(1, 1'b1);
        wait_idle();

        // Small grid walked through its end and around again.
        set_sizes(5'd1, 5'd1, 5'd2, 5'd3);
        queue_words(1, 1'b1);
        queue_words(6, 1'b0);
        wait_idle();

        set_sizes(5'd16, 5'd16, 5'd16, 5'd16);
        queue_words(1, 1'b1);
        queue_words(3, 1'b0);
        wait_idle();

        // Zero acts as one and oversize values clamp to the maximum extent.
        set_sizes(5'd0, 5'd31, 5'd17, 5'd2);
        queue_words(1, 1'b1);
        queue_words(4, 1'b0);
        wait_idle();

        // Shrink the grid under the stored coordinates.
        set_sizes(5'd2, 5'd2, 5'd1, 5'd1);
        queue_words(4, 1'b0);
        wait_idle();

        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase == 3)
            begin
                set_sizes(5'd16, 5'd16, 5'd16, 5'd16);
            end
            else if (phase == 6)
            begin
                set_sizes(5'd1, 5'd1, 5'd1, 5'd16);
            end
            else
            begin
                set_sizes(pick_size(), pick_size(), pick_size(), pick_size());
            end
            repeat (60) add_word($urandom_range(0, 15) == 0);
            wait_idle();
        end

        if (mismatches == 0)
        begin
            $display("snake_order_index_generator_core_tb passed");
        end
        else
        begin
            $display("snake_order_index_generator_core_tb failed");
        end
        $finish;
    end

    initial
    begin
        #500us;
        $display("snake_order_index_generator_core_tb failed");
        $finish;
    end

endmodule

FILE: snake_order_index_generator_core.f
+incdir+rtl
rtl/snoic_pkg.sv
rtl/snoic_cell.sv
rtl/snoic_mac_stage.sv
rtl/snake_order_index_generator_core.sv
rtl/snoic_checker.sv
bench/snake_order_index_generator_core_tb.sv
